// ===== rtl/text_console_writer_top_defines.svh =====
// Assertion macros for the console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
package tcw_pkg;

    localparam int CELL_W     = 16;
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int CLR_W      = 4;
    localparam int ATTR_W     = 2 * CLR_W;
    localparam int CFG_IDX_W  = 1;
    localparam int LIN_W      = 16;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [CELL_W-1:0] CELL_RESET = 16'h0720;

    localparam logic [CLR_W-1:0] FG_RESET = 4'd7;
    localparam logic [CLR_W-1:0] BG_RESET = 4'd0;

    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_BLANK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              done;
        logic [CELL_W-1:0] cell_data;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_result;

endpackage

// ===== rtl/tcw_store.sv =====
`timescale 1ns / 1ps
module tcw_store
    import tcw_pkg::*;
#(
    parameter int DEPTH = DEF_ROWS * DEF_COLUMNS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [CELL_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [CELL_W-1:0]        o_rdata
);

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tcw_seq.sv =====
`timescale 1ns / 1ps
`include "text_console_writer_top_defines.svh"
module tcw_seq
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [CMD_W-1:0]                 i_cmd,
    input  logic [CHAR_W-1:0]                i_char_code,
    input  logic [ROW_W-1:0]                 i_read_row,
    input  logic [COL_W-1:0]                 i_read_col,
    input  logic [ATTR_W-1:0]                i_attr,
    input  logic                             i_out_free,
    output t_result                          o_result,
    output logic                             o_mem_we,
    output logic [$clog2(ROWS*COLUMNS)-1:0]  o_mem_waddr,
    output logic [CELL_W-1:0]                o_mem_wdata,
    output logic [$clog2(ROWS*COLUMNS)-1:0]  o_mem_raddr,
    input  logic [CELL_W-1:0]                i_mem_rdata
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [AW-1:0] LAST_ADDR  = AW'(CELLS - 1);
    localparam logic [AW-1:0] SCROLL_END = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0] ROW_STEP   = AW'(COLUMNS);
    localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);

    t_state            r_state, n_state;
    logic [RW-1:0]     r_row, n_row;
    logic [CW-1:0]     r_col, n_col;
    logic [AW-1:0]     r_addr, n_addr;
    logic [CELL_W-1:0] r_cell, n_cell;

    t_cmd              cmd;
    logic              accept;
    logic              is_newline;
    logic              is_return;
    logic              is_glyph;
    logic              rd_in_range;
    logic [LIN_W-1:0]  rd_lin;
    logic [LIN_W-1:0]  cur_lin;

    assign cmd         = t_cmd'(i_cmd);
    assign accept      = (r_state == ST_IDLE) && i_in_valid;
    assign is_newline  = (i_char_code == CH_NEWLINE);
    assign is_return   = (i_char_code == CH_RETURN);
    assign is_glyph    = (cmd == CMD_PUT) && !is_newline && !is_return;
    assign rd_lin      = LIN_W'(i_read_row) * LIN_W'(COLUMNS) + LIN_W'(i_read_col);
    assign cur_lin     = LIN_W'(r_row) * LIN_W'(COLUMNS) + LIN_W'(r_col);
    assign rd_in_range = (LIN_W'(i_read_row) < LIN_W'(ROWS))
                      && (LIN_W'(i_read_col) < LIN_W'(COLUMNS));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (r_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (cmd)
                        CMD_PUT: begin
                            if (is_newline) begin
                                n_state = (r_row == LAST_ROW) ? ST_SCROLL : ST_DONE;
                            end else if (is_return) begin
                                n_state = ST_DONE;
                            end else begin
                                n_state = (r_col == LAST_COL && r_row == LAST_ROW)
                                        ? ST_SCROLL : ST_DONE;
                            end
                        end
                        CMD_CLEAR: n_state = ST_BLANK;
                        CMD_READ:  n_state = rd_in_range ? ST_READ : ST_DONE;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_READ: n_state = ST_DONE;
            ST_SCROLL: begin
                if (r_addr == SCROLL_END) begin
                    n_state = ST_BLANK;
                end
            end
            ST_BLANK: begin
                if (r_addr == LAST_ADDR) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_addr = r_addr;
        n_cell = r_cell;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cell = '0;
                    n_addr = '0;
                    case (cmd)
                        CMD_PUT: begin
                            if (is_newline || is_return || r_col == LAST_COL) begin
                                n_col = '0;
                                if (!is_return && r_row != LAST_ROW) begin
                                    n_row = r_row + 1'b1;
                                end
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            n_row = '0;
                            n_col = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: n_cell = i_mem_rdata;
            ST_SCROLL: begin
                if (r_addr != SCROLL_END) begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_INIT, ST_BLANK: begin
                if (r_addr != LAST_ADDR) begin
                    n_addr = r_addr + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_mem_we    = 1'b0;
        o_mem_waddr = r_addr;
        o_mem_wdata = {i_attr, CH_SPACE};
        o_mem_raddr = AW'(rd_lin);
        case (r_state)
            ST_INIT: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = CELL_RESET;
            end
            ST_IDLE: begin
                if (accept && is_glyph) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = AW'(cur_lin);
                    o_mem_wdata = {i_attr, i_char_code};
                end
            end
            ST_SCROLL: begin
                o_mem_raddr = r_addr + ROW_STEP;
                o_mem_we    = (r_addr != '0);
                o_mem_waddr = r_addr - 1'b1;
                o_mem_wdata = i_mem_rdata;
            end
            ST_BLANK: o_mem_we = 1'b1;
            default: ;
        endcase
        o_result.done      = (r_state == ST_DONE) && i_out_free;
        o_result.cell_data = r_cell;
        o_result.row       = ROW_W'(r_row);
        o_result.col       = COL_W'(r_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_row   <= '0;
            r_col   <= '0;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_addr  <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    `TCW_ASSERT_NOW(a_row_range, 1'b1, r_row <= LAST_ROW, "cursor row beyond last row")
    `TCW_ASSERT_NOW(a_col_range, 1'b1, r_col <= LAST_COL, "cursor column beyond last column")
    `TCW_ASSERT_NEXT(a_read_wait, accept && cmd == CMD_READ && rd_in_range, r_state == ST_READ, "in-range read did not wait for store data")
    `TCW_ASSERT_NOW(a_no_write_idle_out, r_state == ST_READ || r_state == ST_DONE, !o_mem_we, "store written while finishing an item")

endmodule

// ===== rtl/text_console_writer_top.sv =====
`timescale 1ns / 1ps
// Channel  Valid        Stall        Word
// in       i_in_valid   o_in_stall   i_cmd, i_char_code, i_read_row, i_read_col
// out      o_out_valid  i_out_stall  o_cell_data, o_cursor_row, o_cursor_col
// cfg      i_cfg_we     -            i_cfg_index, i_cfg_data
//
// A put goes from idle straight to done unless it scrolls; an in-range read passes
// through the read state first. A scroll copies the rows up then blanks the bottom
// row, a clear blanks every cell; both go through the single store write port.
// After reset a clearing pass over all ROWS*COLUMNS cells (2000 at 80x25) fills the
// store with grey-on-black spaces; o_in_stall is high meanwhile.
// The output register frees the sequencer once a word is held; a held word
// stalls the next item only in its done state.
module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic [ROW_W-1:0]     i_read_row,
    input  logic [COL_W-1:0]     i_read_col,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CELL_W-1:0]    o_cell_data,
    output logic [ROW_W-1:0]     o_cursor_row,
    output logic [COL_W-1:0]     o_cursor_col,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CLR_W-1:0]     i_cfg_data
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    logic [CLR_W-1:0]  r_fg;
    logic [CLR_W-1:0]  r_bg;
    logic              r_out_valid;
    logic [CELL_W-1:0] r_cell_data;
    logic [ROW_W-1:0]  r_cursor_row;
    logic [COL_W-1:0]  r_cursor_col;

    logic              out_free;
    t_result           result;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FG_COLOR: r_fg <= i_cfg_data;
                REG_BG_COLOR: r_bg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.done) begin
            r_cell_data  <= result.cell_data;
            r_cursor_row <= result.row;
            r_cursor_col <= result.col;
        end
    end

    tcw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_char_code (i_char_code),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .i_attr      ({r_bg, r_fg}),
        .i_out_free  (out_free),
        .o_result    (result),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    tcw_store #(
        .DEPTH (CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_cell_data  = r_cell_data;
    assign o_cursor_row = r_cursor_row;
    assign o_cursor_col = r_cursor_col;

endmodule

// ===== tb/console_scoreboard.sv =====
`timescale 1ns / 1ps
module console_scoreboard
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic [ROW_W-1:0]     i_read_row,
    input  logic [COL_W-1:0]     i_read_col,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [CELL_W-1:0]    i_cell_data,
    input  logic [ROW_W-1:0]     i_cursor_row,
    input  logic [COL_W-1:0]     i_cursor_col,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CLR_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int CELLS = ROWS * COLUMNS;

    typedef struct packed {
        logic [CELL_W-1:0] cell_data;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_console_word;

    logic [CELL_W-1:0] screen [CELLS];
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [CLR_W-1:0]  fg_color;
    logic [CLR_W-1:0]  bg_color;
    t_console_word     expected_words[$];
    int                fails = 0;

    function automatic logic [CELL_W-1:0] paint(input logic [CHAR_W-1:0] ch);
        return {bg_color, fg_color, ch};
    endfunction

    task automatic reset_console();
        int i;
        for (i = 0; i < CELLS; i++) screen[i] = CELL_RESET;
        cur_row  = '0;
        cur_col  = '0;
        fg_color = FG_RESET;
        bg_color = BG_RESET;
    endtask

    task automatic fill_blank();
        int i;
        for (i = 0; i < CELLS; i++) screen[i] = paint(CH_SPACE);
    endtask

    task automatic scroll_up_one();
        int i;
        for (i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
        for (i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = paint(CH_SPACE);
    endtask

    task automatic line_feed();
        cur_col = '0;
        if (int'(cur_row) >= ROWS - 1) begin
            scroll_up_one();
            cur_row = ROW_W'(ROWS - 1);
        end else begin
            cur_row = cur_row + 1'b1;
        end
    endtask

    task automatic console_step(input t_cmd op, input logic [CHAR_W-1:0] ch,
                                input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc,
                                output t_console_word res);
        res.cell_data = '0;
        case (op)
            CMD_PUT: begin
                if (ch == CH_NEWLINE) begin
                    line_feed();
                end else if (ch == CH_RETURN) begin
                    cur_col = '0;
                end else begin
                    screen[int'(cur_row) * COLUMNS + int'(cur_col)] = paint(ch);
                    if (int'(cur_col) >= COLUMNS - 1) line_feed();
                    else cur_col = cur_col + 1'b1;
                end
            end
            CMD_CLEAR: begin
                fill_blank();
                cur_row = '0;
                cur_col = '0;
            end
            CMD_READ: begin
                if (int'(rr) < ROWS && int'(rc) < COLUMNS)
                    res.cell_data = screen[int'(rr) * COLUMNS + int'(rc)];
            end
            default: ;
        endcase
        res.row = cur_row;
        res.col = cur_col;
    endtask

    always @(posedge i_clk) begin : watch
        t_console_word want;
        if (!i_rst_n) begin
            reset_console();
            expected_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("word with no prediction: cell_data %h cursor_row %0d cursor_col %0d",
                           i_cell_data, i_cursor_row, i_cursor_col);
                    fails++;
                end else begin
                    want = expected_words.pop_front();
                    if (i_cell_data !== want.cell_data) begin
                        $error("cell_data: expected %h, got %h", want.cell_data, i_cell_data);
                        fails++;
                    end
                    if (i_cursor_row !== want.row) begin
                        $error("cursor_row: expected %0d, got %0d", want.row, i_cursor_row);
                        fails++;
                    end
                    if (i_cursor_col !== want.col) begin
                        $error("cursor_col: expected %0d, got %0d", want.col, i_cursor_col);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                console_step(t_cmd'(i_cmd), i_char_code, i_read_row, i_read_col, want);
                expected_words.push_back(want);
            end
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FG_COLOR) fg_color = i_cfg_data;
                else if (i_cfg_index == REG_BG_COLOR) bg_color = i_cfg_data;
            end
        end
        o_pending    <= expected_words.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/text_console_writer_top_test.sv =====
`timescale 1ns / 1ps
module text_console_writer_top_test;
    import tcw_pkg::*;

    localparam int COLUMNS    = DEF_COLUMNS;
    localparam int ROWS       = DEF_ROWS;
    localparam int TIMEOUT_NS = 50_000_000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [CMD_W-1:0]     i_cmd;
    logic [CHAR_W-1:0]    i_char_code;
    logic [ROW_W-1:0]     i_read_row;
    logic [COL_W-1:0]     i_read_col;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [CELL_W-1:0]    o_cell_data;
    logic [ROW_W-1:0]     o_cursor_row;
    logic [COL_W-1:0]     o_cursor_col;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CLR_W-1:0]     i_cfg_data;

    int fail_count;
    int pending;
    bit quiet = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    text_console_writer_top #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_char_code (i_char_code),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cell_data (o_cell_data),
        .o_cursor_row(o_cursor_row),
        .o_cursor_col(o_cursor_col),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    console_scoreboard #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_char_code (i_char_code),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cell_data (o_cell_data),
        .i_cursor_row(o_cursor_row),
        .i_cursor_col(o_cursor_col),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    task automatic send_word(input t_cmd op, input logic [CHAR_W-1:0] ch,
                             input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= op;
        i_char_code <= ch;
        i_read_row  <= rr;
        i_read_col  <= rc;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // drop valid and hold until every predicted word has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_colors(input logic [CLR_W-1:0] fg, input logic [CLR_W-1:0] bg);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_FG_COLOR;
        i_cfg_data  <= fg;
        @(posedge i_clk);
        i_cfg_index <= REG_BG_COLOR;
        i_cfg_data  <= bg;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // mix 0: newline heavy, 1: long text runs, 2 and up: general with clears
    task automatic random_word(input int mix);
        int                roll;
        int                pick;
        t_cmd              op;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  rr;
        logic [COL_W-1:0]  rc;
        roll = $urandom_range(0, 99);
        ch   = CHAR_W'($urandom_range(0, 255));
        op   = CMD_READ;
        case (mix)
            0: begin
                if (roll < 30) begin op = CMD_PUT; ch = CH_NEWLINE; end
                else if (roll < 35) begin op = CMD_PUT; ch = CH_RETURN; end
                else if (roll < 65) op = CMD_PUT;
                else if (roll >= 95) op = CMD_NOP;
            end
            1: begin
                if (roll < 2) begin op = CMD_PUT; ch = CH_NEWLINE; end
                else if (roll < 85) op = CMD_PUT;
                else if (roll >= 97) op = CMD_NOP;
            end
            default: begin
                if (roll < 10) begin op = CMD_PUT; ch = CH_NEWLINE; end
                else if (roll < 13) begin op = CMD_PUT; ch = CH_RETURN; end
                else if (roll < 55) op = CMD_PUT;
                else if (roll < 58) op = CMD_CLEAR;
                else if (roll >= 90) op = CMD_NOP;
            end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            rr = ROW_W'($urandom_range(0, 31));
            rc = COL_W'($urandom_range(0, 127));
        end else if (pick < 50) begin
            rr = ROW_W'($urandom_range(ROWS - 2, ROWS - 1));
            rc = COL_W'($urandom_range(0, COLUMNS - 1));
        end else begin
            rr = ROW_W'($urandom_range(0, ROWS - 1));
            rc = COL_W'($urandom_range(0, COLUMNS - 1));
        end
        send_word(op, ch, rr, rc);
    endtask

    // receiver: random stall bursts, none once quiet
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            if (quiet) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("** text_console_writer_top: FAILED **");
        $finish;
    end

    initial begin
        int phase;
        int count;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_cmd       <= CMD_NOP;
        i_char_code <= '0;
        i_read_row  <= '0;
        i_read_col  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_FG_COLOR;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset store, out-of-range reads, unused command
        send_word(CMD_READ, 8'h00, '0, '0);
        send_word(CMD_READ, 8'hFF, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
        send_word(CMD_READ, 8'h00, ROW_W'(ROWS), '0);
        send_word(CMD_READ, 8'h00, '0, COL_W'(COLUMNS));
        send_word(CMD_READ, 8'hFF, '1, '1);
        send_word(CMD_NOP, 8'hFF, '1, '1);
        // plain characters, carriage return overwrite, newline
        send_word(CMD_PUT, 8'h41, '1, '1);
        send_word(CMD_PUT, 8'h00, '0, '0);
        send_word(CMD_PUT, 8'hFF, '1, '0);
        send_word(CMD_PUT, CH_RETURN, '0, '1);
        send_word(CMD_PUT, 8'h42, '0, '0);
        send_word(CMD_PUT, CH_NEWLINE, '0, '0);
        send_word(CMD_READ, 8'h00, '0, '0);
        send_word(CMD_READ, 8'h00, '0, 7'd1);
        send_word(CMD_READ, 8'h00, '0, 7'd2);

        // colors apply only to later writes; clear uses them
        wait_drained();
        set_colors('1, '1);
        send_word(CMD_PUT, 8'h43, '0, '0);
        send_word(CMD_READ, 8'h00, 5'd1, '0);
        send_word(CMD_READ, 8'h00, '0, '0);
        send_word(CMD_CLEAR, 8'hFF, '1, '1);
        send_word(CMD_READ, 8'h00, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
        send_word(CMD_READ, 8'h00, '0, '0);
        send_word(CMD_READ, 8'h00, 5'd1, '0);

        for (phase = 0; phase < 4; phase++) begin
            wait_drained();
            case (phase)
                0: set_colors('0, '0);
                2: set_colors('1, CLR_W'($urandom_range(0, 15)));
                default: set_colors(CLR_W'($urandom_range(0, 15)),
                                    CLR_W'($urandom_range(0, 15)));
            endcase
            if (phase == 3) quiet = 1'b1;
            case (phase)
                0: count = 100;
                1: count = 150;
                2: count = 100;
                default: count = 60;
            endcase
            repeat (count) random_word(phase);
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("** text_console_writer_top: PASSED **");
        else
            $display("** text_console_writer_top: FAILED **");
        $finish;
    end

endmodule
